/* src/master_stack_tile_layout_macros.svh */
// ----------------------------------------------------------------------------
// master_stack_tile_layout_macros
// Assertion macros shared by the tiling layout block.
// ----------------------------------------------------------------------------
`ifndef MASTER_STACK_TILE_LAYOUT_MACROS_SVH
`define MASTER_STACK_TILE_LAYOUT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define MSTL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mstl: implication check failed");

// next-cycle implication, clocked on clk, off during rst
`define MSTL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mstl: next-cycle check failed");

`endif

/* src/mstl_pkg.sv */
// ----------------------------------------------------------------------------
// mstl_pkg
// Widths, register map, config and word types of the tiling layout block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mstl_pkg;

  localparam int unsigned DIM_W    = 14;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned GAP_W    = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned BORDER_W = 8;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned CALC_W   = 20;
  localparam int unsigned QUO_W    = 16;
  localparam int unsigned DVS_W    = 9;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam int MAX_WINDOWS_DEF = 256;

  typedef enum logic [2:0] {
    REG_AREA_X,
    REG_AREA_Y,
    REG_AREA_WIDTH,
    REG_AREA_HEIGHT,
    REG_MASTER_SLOTS,
    REG_MASTER_FRACTION,
    REG_GAP_PIXELS,
    REG_GAPS_ON
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  area_x;
    logic [DIM_W-1:0]  area_y;
    logic [DIM_W-1:0]  area_width;
    logic [DIM_W-1:0]  area_height;
    logic [SLOT_W-1:0] master_slots;
    logic [FRAC_W-1:0] master_fraction;
    logic [GAP_W-1:0]  gap_pixels;
    logic              gaps_on;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    area_x:          14'd0,
    area_y:          14'd0,
    area_width:      14'd1920,
    area_height:     14'd1080,
    master_slots:    8'd1,
    master_fraction: 16'd36045,
    gap_pixels:      8'd0,
    gaps_on:         1'b0
  };

  typedef struct packed {
    logic                start_req;
    logic [COUNT_W-1:0]  total_windows;
    logic [BORDER_W-1:0] border_width;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] size_w;
    logic signed [COORD_W-1:0] size_h;
  } out_word_t;

endpackage

/* src/mstl_regs.sv */
// ----------------------------------------------------------------------------
// mstl_regs
// APB register file holding the layout configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstl_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mstl_pkg::ADDR_W-1:0]   paddr,
  input  logic [mstl_pkg::DATA_W-1:0]   pwdata,
  output logic [mstl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mstl_pkg::cfg_t                cfg
);

  mstl_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = mstl_pkg::reg_idx_t'(paddr[mstl_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= mstl_pkg::CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        mstl_pkg::REG_AREA_X:          cfg.area_x <= pwdata[mstl_pkg::DIM_W-1:0];
        mstl_pkg::REG_AREA_Y:          cfg.area_y <= pwdata[mstl_pkg::DIM_W-1:0];
        mstl_pkg::REG_AREA_WIDTH:      cfg.area_width <= pwdata[mstl_pkg::DIM_W-1:0];
        mstl_pkg::REG_AREA_HEIGHT:     cfg.area_height <= pwdata[mstl_pkg::DIM_W-1:0];
        mstl_pkg::REG_MASTER_SLOTS:    cfg.master_slots <= pwdata[mstl_pkg::SLOT_W-1:0];
        mstl_pkg::REG_MASTER_FRACTION: cfg.master_fraction <= pwdata[mstl_pkg::FRAC_W-1:0];
        mstl_pkg::REG_GAP_PIXELS:      cfg.gap_pixels <= pwdata[mstl_pkg::GAP_W-1:0];
        mstl_pkg::REG_GAPS_ON:         cfg.gaps_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mstl_pkg::REG_AREA_X:          prdata = mstl_pkg::DATA_W'(cfg.area_x);
      mstl_pkg::REG_AREA_Y:          prdata = mstl_pkg::DATA_W'(cfg.area_y);
      mstl_pkg::REG_AREA_WIDTH:      prdata = mstl_pkg::DATA_W'(cfg.area_width);
      mstl_pkg::REG_AREA_HEIGHT:     prdata = mstl_pkg::DATA_W'(cfg.area_height);
      mstl_pkg::REG_MASTER_SLOTS:    prdata = mstl_pkg::DATA_W'(cfg.master_slots);
      mstl_pkg::REG_MASTER_FRACTION: prdata = mstl_pkg::DATA_W'(cfg.master_fraction);
      mstl_pkg::REG_GAP_PIXELS:      prdata = mstl_pkg::DATA_W'(cfg.gap_pixels);
      mstl_pkg::REG_GAPS_ON:         prdata = mstl_pkg::DATA_W'(cfg.gaps_on);
      default:                       prdata = '0;
    endcase
  end

endmodule

/* src/mstl_div.sv */
// ----------------------------------------------------------------------------
// mstl_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstl_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mstl_pkg::QUO_W-1:0]   dividend,
  input  logic [mstl_pkg::DVS_W-1:0]   divisor,
  output logic                         busy,
  output logic [mstl_pkg::QUO_W-1:0]   quotient
);

  localparam int unsigned CNT_W = $clog2(mstl_pkg::QUO_W);

  logic [mstl_pkg::QUO_W-1:0] dvd;
  logic [mstl_pkg::DVS_W-1:0] dvs;
  logic [mstl_pkg::DVS_W:0]   rem;
  logic [mstl_pkg::DVS_W:0]   rem_shift;
  logic [mstl_pkg::DVS_W:0]   rem_diff;
  logic                       fits;
  logic [CNT_W-1:0]           cnt;

  always_comb begin
    rem_shift = {rem[mstl_pkg::DVS_W-1:0], dvd[mstl_pkg::QUO_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs};
    fits      = rem_shift >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(mstl_pkg::QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend register shifts out on top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? rem_diff : rem_shift;
      dvd <= {dvd[mstl_pkg::QUO_W-2:0], fits};
    end
  end

  assign quotient = dvd;

endmodule

/* src/mstl_mul.sv */
// ----------------------------------------------------------------------------
// mstl_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstl_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mstl_pkg::DIM_W-1:0]    multiplicand,
  input  logic [mstl_pkg::FRAC_W-1:0]   multiplier,
  output logic                          busy,
  output logic [mstl_pkg::DIM_W-1:0]    product_hi
);

  localparam int unsigned CNT_W = $clog2(mstl_pkg::FRAC_W);
  localparam int unsigned ACC_W = mstl_pkg::DIM_W + mstl_pkg::FRAC_W;

  logic [ACC_W-1:0]              acc;
  logic [mstl_pkg::FRAC_W-1:0]   msr;
  logic [mstl_pkg::DIM_W-1:0]    mcd;
  logic [mstl_pkg::DIM_W:0]      sum;
  logic [CNT_W-1:0]              cnt;

  assign sum = {1'b0, acc[ACC_W-1 -: mstl_pkg::DIM_W]} + (msr[0] ? {1'b0, mcd} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(mstl_pkg::FRAC_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      msr <= multiplier;
      mcd <= multiplicand;
    end else if (busy) begin
      acc <= {sum, acc[mstl_pkg::FRAC_W-1:1]};
      msr <= msr >> 1;
    end
  end

  assign product_hi = acc[ACC_W-1 -: mstl_pkg::DIM_W];

endmodule

/* src/master_stack_tile_layout.sv */
// ----------------------------------------------------------------------------
// master_stack_tile_layout
// Master/stack tiling: one window rectangle per input word with a nonzero window count.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/ready   | in_word  (start_req, total_windows, border_width)
// out     | output    | out_valid/ready  | out_word (pos_x, pos_y, size_w, size_h)
// cfg     | input     | APB psel/penable | paddr, pwdata, prdata
//
// One word at a time: in_ready is low from acceptance until the result is stored.
// The serial divider, started in the setup step, sets how long a word takes;
// the serial master-width multiplier runs beside it.
// A word with zero windows only applies its restart and is done next cycle.
// A result waiting on out_ready holds the block in its last step.
// rst is synchronous and restores register defaults and zero state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "master_stack_tile_layout_macros.svh"

module master_stack_tile_layout #(
  parameter int MAX_WINDOWS = mstl_pkg::MAX_WINDOWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mstl_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mstl_pkg::out_word_t           out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mstl_pkg::ADDR_W-1:0]   paddr,
  input  logic [mstl_pkg::DATA_W-1:0]   pwdata,
  output logic [mstl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned CW = mstl_pkg::CALC_W;
  localparam int unsigned OW = mstl_pkg::COORD_W;
  localparam int unsigned NW = mstl_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_POST1,
    S_POST2
  } state_t;

  state_t                         state;
  mstl_pkg::cfg_t                 cfg;

  logic [NW-1:0]                  slot_index;
  logic signed [OW-1:0]           master_offset;
  logic signed [OW-1:0]           stack_offset;
  logic [NW-1:0]                  n_q;
  logic [mstl_pkg::BORDER_W-1:0]  b_q;
  logic                           in_master_q;
  logic                           neg_q;
  logic signed [CW-1:0]           h_q;
  logic signed [CW-1:0]           mw_q;

  logic                           in_accept;
  logic                           unit_start;
  logic                           div_busy;
  logic                           mul_busy;
  logic [mstl_pkg::QUO_W-1:0]     quotient;
  logic [mstl_pkg::DIM_W-1:0]     frac_w;

  // word intake
  logic [NW-1:0]                  n_clamp;
  logic signed [OW-1:0]           start_off;

  // setup
  logic                           in_master_c;
  logic [NW-1:0]                  m_count;
  logic signed [NW+1:0]           dv_raw;
  logic [mstl_pkg::DVS_W-1:0]     dvs_c;
  logic signed [OW-1:0]           off_c;
  logic signed [CW-1:0]           num_c;
  logic signed [CW-1:0]           mag_c;

  // post
  logic signed [CW-1:0]           wx_e, wy_e, ww_e, wh_e, g_e, b_e, b2_e, my_e, ty_e;
  logic signed [CW-1:0]           q_s;
  logic signed [CW-1:0]           h_c;
  logic signed [CW-1:0]           mw_c;
  logic signed [CW-1:0]           px, py, pw, ph, adv;
  logic signed [OW-1:0]           my_next, ty_next;

  mstl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mstl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (unit_start),
    .dividend (mag_c[mstl_pkg::QUO_W-1:0]),
    .divisor  (dvs_c),
    .busy     (div_busy),
    .quotient (quotient)
  );

  mstl_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (unit_start),
    .multiplicand (cfg.area_width),
    .multiplier   (cfg.master_fraction),
    .busy         (mul_busy),
    .product_hi   (frac_w)
  );

  assign in_ready   = (state == S_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign unit_start = (state == S_SETUP);

  always_comb begin
    n_clamp   = (int'(in_word.total_windows) > MAX_WINDOWS) ? NW'(MAX_WINDOWS)
                                                            : in_word.total_windows;
    start_off = cfg.gaps_on ? OW'(cfg.gap_pixels) : '0;
  end

  // divisor, signed numerator and its magnitude (the divider's dividend) for this slot
  always_comb begin
    in_master_c = slot_index < {1'b0, cfg.master_slots};
    m_count     = (n_q < {1'b0, cfg.master_slots}) ? n_q : {1'b0, cfg.master_slots};
    dv_raw      = signed'({2'b00, (in_master_c ? m_count : n_q)})
                - signed'({2'b00, slot_index});
    dvs_c       = (dv_raw <= 0) ? mstl_pkg::DVS_W'(1) : dv_raw[mstl_pkg::DVS_W-1:0];
    off_c       = in_master_c ? master_offset : stack_offset;
    num_c       = signed'(CW'(cfg.area_height))
                - signed'({{(CW-OW){off_c[OW-1]}}, off_c});
    mag_c       = num_c[CW-1] ? -num_c : num_c;
  end

  always_comb begin
    wx_e = signed'(CW'(cfg.area_x));
    wy_e = signed'(CW'(cfg.area_y));
    ww_e = signed'(CW'(cfg.area_width));
    wh_e = signed'(CW'(cfg.area_height));
    g_e  = signed'(CW'(cfg.gap_pixels));
    b_e  = signed'(CW'(b_q));
    b2_e = b_e + b_e;
    my_e = signed'({{(CW-OW){master_offset[OW-1]}}, master_offset});
    ty_e = signed'({{(CW-OW){stack_offset[OW-1]}}, stack_offset});

    q_s  = neg_q ? -signed'(CW'(quotient)) : signed'(CW'(quotient));
    h_c  = cfg.gaps_on ? q_s - g_e : q_s;
    if (n_q > {1'b0, cfg.master_slots}) begin
      mw_c = (cfg.master_slots != '0) ? signed'(CW'(frac_w)) : '0;
    end else begin
      mw_c = cfg.gaps_on ? ww_e - g_e : ww_e;
    end
  end

  always_comb begin
    px      = '0;
    py      = '0;
    pw      = '0;
    ph      = '0;
    adv     = '0;
    my_next = master_offset;
    ty_next = stack_offset;
    if (cfg.gaps_on) begin
      ph = h_q - b2_e;
      if (in_master_q) begin
        px  = wx_e + g_e;
        py  = wy_e + my_e;
        pw  = mw_q - b2_e - g_e;
        adv = my_e + h_q + b2_e + g_e;
        if (adv < wh_e) begin
          my_next = adv[OW-1:0];
        end
      end else begin
        px  = wx_e + mw_q + g_e;
        py  = wy_e + ty_e;
        pw  = ww_e - mw_q - b2_e - g_e - g_e;
        adv = ty_e + h_q + b2_e + g_e;
        if (adv < wh_e) begin
          ty_next = adv[OW-1:0];
        end
      end
    end else begin
      if (in_master_q) begin
        adv     = my_e + h_q - b_e;
        my_next = adv[OW-1:0];
        px      = wx_e - b_e;
        if (n_q == NW'(1)) begin
          py = wy_e;
          pw = ww_e;
          ph = wh_e;
        end else begin
          py = wy_e + my_e;
          pw = mw_q - b_e;
          ph = h_q - b_e;
        end
      end else begin
        adv     = ty_e + h_q - b_e;
        ty_next = adv[OW-1:0];
        px      = wx_e + mw_q - b_e;
        py      = wy_e + ty_e;
        pw      = ww_e - mw_q;
        ph      = h_q - b_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      slot_index    <= '0;
      master_offset <= '0;
      stack_offset  <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_POST2)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            n_q <= n_clamp;
            b_q <= in_word.border_width;
            if (in_word.start_req) begin
              slot_index    <= '0;
              master_offset <= start_off;
              stack_offset  <= start_off;
            end
            state <= (in_word.total_windows == '0) ? S_IDLE : S_SETUP;
          end
        end
        S_SETUP: begin
          in_master_q <= in_master_c;
          neg_q       <= num_c[CW-1];
          state       <= S_RUN;
        end
        S_RUN: begin
          if (!div_busy) begin
            state <= S_POST1;
          end
        end
        S_POST1: begin
          h_q   <= h_c;
          mw_q  <= mw_c;
          state <= S_POST2;
        end
        S_POST2: begin
          if (!out_valid || out_ready) begin
            out_word.pos_x <= px[OW-1:0];
            out_word.pos_y <= py[OW-1:0];
            out_word.size_w <= pw[OW-1:0];
            out_word.size_h <= ph[OW-1:0];
            out_valid      <= 1'b1;
            master_offset  <= my_next;
            stack_offset   <= ty_next;
            slot_index     <= slot_index + 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MSTL_ASSERT_IMP(a_units_lockstep, 1'b1, div_busy == mul_busy)
  `MSTL_ASSERT_NXT(a_empty_pass_idle, in_accept && (in_word.total_windows == '0), state == S_IDLE)
  `MSTL_ASSERT_IMP(a_result_from_post, $rose(out_valid), $past(state) == S_POST2)
  `MSTL_ASSERT_NXT(a_run_exit, (state == S_RUN) && !div_busy, state == S_POST1)

endmodule

/* tb/master_stack_tile_layout_checker.sv */
// ----------------------------------------------------------------------------
// master_stack_tile_layout_checker
// Watches the register port and both word channels of the tiling block,
// tracks its registers, slot index and column offsets, predicts one window
// rectangle per accepted input word with a nonzero window count and compares
// each output word with the oldest prediction. Mismatches and stray output words are counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module master_stack_tile_layout_checker
  import mstl_pkg::*;
#(
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_word_t            in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_word_t           out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  output int unsigned         errors,
  output int unsigned         pending,
  output int unsigned         checked
);

  cfg_t               setup;
  logic [COUNT_W-1:0] slot_idx;
  logic [COORD_W-1:0] master_y;
  logic [COORD_W-1:0] stack_y;
  out_word_t          rect_q[$];

  function automatic longint split_height(input longint space, input longint slots_left);
    if (slots_left <= 0) slots_left = 1;
    return space / slots_left;
  endfunction

  // returns 1 when the word places a window; updates index and offsets
  function automatic bit place_window(input in_word_t w, output out_word_t rect);
    longint n, b, wx, wy, ww, wh, slots, g, i, my, ty, mw, h, frac_w, px, py, pw, ph;
    rect = '0;
    if (w.start_req) begin
      slot_idx = '0;
      master_y = setup.gaps_on ? COORD_W'(setup.gap_pixels) : '0;
      stack_y  = master_y;
    end
    n = w.total_windows;
    if (n == 0) return 1'b0;
    if (n > MAX_WINDOWS) n = MAX_WINDOWS;
    b     = w.border_width;
    wx    = setup.area_x;
    wy    = setup.area_y;
    ww    = setup.area_width;
    wh    = setup.area_height;
    slots = setup.master_slots;
    g     = setup.gap_pixels;
    i     = slot_idx;
    my    = longint'($signed(master_y));
    ty    = longint'($signed(stack_y));
    frac_w = (ww * longint'(setup.master_fraction)) >> 16;
    if (n > slots) mw = (slots != 0) ? frac_w : 0;
    else mw = setup.gaps_on ? ww - g : ww;

    if (setup.gaps_on) begin
      if (i < slots) begin
        h  = split_height(wh - my, ((n < slots) ? n : slots) - i) - g;
        px = wx + g;
        py = wy + my;
        pw = mw - 2 * b - g;
        ph = h - 2 * b;
        if (my + h + 2 * b + g < wh) my += h + 2 * b + g;
      end else begin
        h  = split_height(wh - ty, n - i) - g;
        px = wx + mw + g;
        py = wy + ty;
        pw = ww - mw - 2 * b - 2 * g;
        ph = h - 2 * b;
        if (ty + h + 2 * b + g < wh) ty += h + 2 * b + g;
      end
    end else begin
      if (i < slots) begin
        h  = split_height(wh - my, ((n < slots) ? n : slots) - i);
        px = wx - b;
        if (n == 1) begin
          py = wy;
          pw = ww;
          ph = wh;
        end else begin
          py = wy + my;
          pw = mw - b;
          ph = h - b;
        end
        my += h - b;
      end else begin
        h  = split_height(wh - ty, n - i);
        px = wx + mw - b;
        py = wy + ty;
        pw = ww - mw;
        ph = h - b;
        ty += h - b;
      end
    end

    master_y    = COORD_W'(my);
    stack_y     = COORD_W'(ty);
    slot_idx    = slot_idx + 1'b1;
    rect.pos_x  = COORD_W'(px);
    rect.pos_y  = COORD_W'(py);
    rect.size_w = COORD_W'(pw);
    rect.size_h = COORD_W'(ph);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_word_t rect;
    out_word_t want;
    if (rst) begin
      setup    = CFG_RESET;
      slot_idx = '0;
      master_y = '0;
      stack_y  = '0;
      rect_q.delete();
      errors   = 0;
      checked  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_AREA_X:          setup.area_x          = pwdata[DIM_W-1:0];
          REG_AREA_Y:          setup.area_y          = pwdata[DIM_W-1:0];
          REG_AREA_WIDTH:      setup.area_width      = pwdata[DIM_W-1:0];
          REG_AREA_HEIGHT:     setup.area_height     = pwdata[DIM_W-1:0];
          REG_MASTER_SLOTS:    setup.master_slots    = pwdata[SLOT_W-1:0];
          REG_MASTER_FRACTION: setup.master_fraction = pwdata[FRAC_W-1:0];
          REG_GAP_PIXELS:      setup.gap_pixels      = pwdata[GAP_W-1:0];
          REG_GAPS_ON:         setup.gaps_on         = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (place_window(in_word, rect)) rect_q.push_back(rect);
      end
      if (out_valid && out_ready) begin
        if (rect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected rectangle (%0d,%0d %0dx%0d)", $time,
                   out_word.pos_x, out_word.pos_y, out_word.size_w, out_word.size_h);
        end else begin
          want = rect_q.pop_front();
          checked++;
          if (out_word !== want) begin
            errors++;
            $display("%0t: rectangle mismatch: expected (%0d,%0d %0dx%0d) got (%0d,%0d %0dx%0d)",
                     $time, want.pos_x, want.pos_y, want.size_w, want.size_h,
                     out_word.pos_x, out_word.pos_y, out_word.size_w, out_word.size_h);
          end
        end
      end
    end
    pending = rect_q.size();
  end

endmodule

/* tb/master_stack_tile_layout_tb.sv */
// ----------------------------------------------------------------------------
// master_stack_tile_layout_tb
// Drives the tiling block with layout passes under many register setups:
// a short directed set of corner cases, random passes (well-formed, cut
// short, overrun and noise words) under three idling patterns, and one long
// pass that runs well past its window count. The checker beside the
// block predicts every rectangle; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module master_stack_tile_layout_tb;
  import mstl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 25;
  localparam int unsigned SEG_WORDS    = 40;
  localparam int unsigned WRAP_WORDS   = 140;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned in_idle = 0;
  int unsigned out_idle = 0;
  int unsigned words_sent = 0;
  int unsigned passes = 0;
  int unsigned setups = 0;

  master_stack_tile_layout uut (
    .clk, .rst, .in_valid, .in_ready, .in_word, .out_valid, .out_ready, .out_word,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  master_stack_tile_layout_checker chk (
    .clk, .rst, .in_valid, .in_ready, .in_word, .out_valid, .out_ready, .out_word,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending, .checked
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d rectangles outstanding", cycles, pending);
      $display("master_stack_tile_layout_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t r, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setup(input cfg_t c);
    write_reg(REG_AREA_X, c.area_x);
    write_reg(REG_AREA_Y, c.area_y);
    write_reg(REG_AREA_WIDTH, c.area_width);
    write_reg(REG_AREA_HEIGHT, c.area_height);
    write_reg(REG_MASTER_SLOTS, c.master_slots);
    write_reg(REG_MASTER_FRACTION, c.master_fraction);
    write_reg(REG_GAP_PIXELS, c.gap_pixels);
    write_reg(REG_GAPS_ON, c.gaps_on);
    setups++;
  endtask

  function automatic cfg_t make_setup(input int unsigned x, y, w, h, slots, frac, gap, gon);
    cfg_t c;
    c.area_x          = DIM_W'(x);
    c.area_y          = DIM_W'(y);
    c.area_width      = DIM_W'(w);
    c.area_height     = DIM_W'(h);
    c.master_slots    = SLOT_W'(slots);
    c.master_fraction = FRAC_W'(frac);
    c.gap_pixels      = GAP_W'(gap);
    c.gaps_on         = gon[0];
    return c;
  endfunction

  // mostly typical values, now and then a field extreme
  function automatic int unsigned skewed(input int unsigned hi, lo, typ_hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return hi;
    return $urandom_range(typ_hi, lo);
  endfunction

  function automatic cfg_t random_setup();
    return make_setup(skewed(16383, 0, 2000), skewed(16383, 0, 2000),
                      skewed(16383, 320, 4000), skewed(16383, 200, 3000),
                      skewed(255, 1, 4), skewed(65535, 8000, 58000),
                      skewed(255, 0, 20), $urandom_range(1));
  endfunction

  function automatic int unsigned pick_border();
    return ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(8);
  endfunction

  task automatic send_word(input bit start, input int unsigned count, border);
    if ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle);
    end
    in_valid <= 1'b1;
    in_word  <= '{start_req: start, total_windows: COUNT_W'(count),
                  border_width: BORDER_W'(border)};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // quiet point: all rectangles back, then room for a zero-window word
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_traffic(input int unsigned target);
    int unsigned placed;
    int unsigned kind;
    int unsigned n;
    int unsigned len;
    placed = 0;
    while (placed < target) begin
      kind = $urandom_range(99);
      if (kind < 87) begin
        if (kind < 75) begin
          n   = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
          len = n;
        end else begin
          n   = $urandom_range(8, 2);
          len = $urandom_range(n + 3, 1);
        end
        for (int unsigned k = 0; k < len; k++) send_word(k == 0, n, pick_border());
        placed += len;
        passes++;
      end else begin
        n = ($urandom_range(2) == 0) ? 0 : $urandom_range(511);
        send_word($urandom_range(1), n, pick_border());
        if (n != 0) placed++;
      end
    end
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_word  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup: gapless, one master slot
    send_word(1'b1, 1, 0);
    send_word(1'b1, 3, 0);
    send_word(1'b0, 3, 255);
    send_word(1'b0, 3, 5);
    send_word(1'b1, 0, 0);
    send_word(1'b0, 3, 2);
    settle();

    apply_setup(make_setup(40, 30, 1920, 1080, 2, 32768, 10, 1));
    send_word(1'b1, 5, 0);
    send_word(1'b0, 5, 255);
    send_word(1'b0, 5, 1);
    send_word(1'b0, 5, 2);
    send_word(1'b0, 5, 3);
    send_word(1'b1, 300, 4);
    send_word(1'b0, 511, 4);
    for (int unsigned k = 0; k < 4; k++) send_word(k == 0, 2, 1);
    send_word(1'b1, 1, 0);
    send_word(1'b0, 1, 0);
    settle();

    apply_setup(make_setup(16383, 16383, 16383, 16383, 255, 65535, 255, 1));
    for (int unsigned k = 0; k < 3; k++) send_word(k == 0, 3, 255);
    settle();

    apply_setup(make_setup(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(1'b1, 2, 255);
    send_word(1'b0, 2, 255);
    settle();

    for (int unsigned ph = 0; ph < 3; ph++) begin
      in_idle  = (ph == 0) ? 16 : (ph == 1) ? 51 : 0;
      out_idle = (ph == 0) ? 51 : (ph == 1) ? 16 : 0;
      for (int unsigned seg = 0; seg < 3; seg++) begin
        apply_setup(random_setup());
        run_traffic(SEG_WORDS);
        settle();
      end
    end

    // one stack pass on a zero-height area, run on past its end
    apply_setup(make_setup(100, 100, 1920, 0, 0, 0, 0, 0));
    for (int unsigned k = 0; k < WRAP_WORDS; k++)
      send_word(k == 0, ($urandom_range(7) == 0) ? $urandom_range(511, 257) : 64,
                $urandom_range(255, 128));
    passes++;
    settle();

    $display("Sent %0d words in %0d passes over %0d register setups, three idling patterns.",
             words_sent, passes, setups);
    $display("Compared %0d rectangles, incl. a long pass run past its window count.",
             checked);
    if (errors == 0) $display("master_stack_tile_layout_tb: PASS");
    else $display("master_stack_tile_layout_tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/mstl_pkg.sv
src/mstl_regs.sv
src/mstl_div.sv
src/mstl_mul.sv
src/master_stack_tile_layout.sv
tb/master_stack_tile_layout_checker.sv
tb/master_stack_tile_layout_tb.sv
